// ===== hw/rtl/tcaod_pkg.sv =====
// Shared constants, codes and types of the two-class arrival-ordered dispatcher.
package tcaod_pkg;

   // Sizes
   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int RUN_BITS    = 16;
   localparam int RES_BITS    = 4;
   localparam int ID_BITS     = 8;
   localparam int PRIO_BITS   = 2;
   localparam int STAT_BITS   = 2;
   localparam int CSR_IDX_BITS = 1;

   // Register reset values
   localparam logic [RES_BITS-1:0] PRINTER_TOTAL_RESET = 4'd2;
   localparam logic [RES_BITS-1:0] CD_TOTAL_RESET      = 4'd2;

   // Command codes
   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_type;

   // Result status codes
   typedef enum logic [STAT_BITS-1:0] {
      STAT_IDLE       = 2'd0,
      STAT_DISPATCHED = 2'd1,
      STAT_REJECTED   = 2'd2,
      STAT_DROPPED    = 2'd3
   } status_type;

   // Job classes
   typedef enum logic {
      CLASS_REALTIME = 1'b0,
      CLASS_USER     = 1'b1
   } class_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PRINTER_TOTAL = 1'b0,
      CSR_CD_TOTAL      = 1'b1
   } csr_index_type;

   // One queued job
   typedef struct packed {
      logic [TIME_BITS-1:0] arrival;
      logic [RUN_BITS-1:0]  run;
      logic [RES_BITS-1:0]  printers;
      logic [RES_BITS-1:0]  cds;
      logic [ID_BITS-1:0]   id;
   } entry_type;

   // Per-cycle operation on one queue
   typedef struct packed {
      logic push;
      logic pop;
   } queue_op_type;

endpackage

// ===== hw/rtl/tcaod_if.sv =====
// Request and response channel interfaces of the dispatcher.
interface tcaod_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [tcaod_pkg::TIME_BITS-1:0]     arrival_time;
   logic [tcaod_pkg::PRIO_BITS-1:0]     job_priority;
   logic [tcaod_pkg::RUN_BITS-1:0]      run_time;
   logic [tcaod_pkg::RES_BITS-1:0]      printers_wanted;
   logic [tcaod_pkg::RES_BITS-1:0]      cds_wanted;

   modport source (output valid, command, arrival_time, job_priority, run_time,
                   printers_wanted, cds_wanted, input ready);
   modport sink   (input valid, command, arrival_time, job_priority, run_time,
                   printers_wanted, cds_wanted, output ready);
endinterface

interface tcaod_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tcaod_pkg::STAT_BITS-1:0]     status;
   logic [tcaod_pkg::ID_BITS-1:0]       job_id;
   logic                                job_class;
   logic [tcaod_pkg::RUN_BITS-1:0]      job_run_time;
   logic                                both_empty;

   modport source (output valid, status, job_id, job_class, job_run_time, both_empty,
                   input ready);
   modport sink   (input valid, status, job_id, job_class, job_run_time, both_empty,
                   output ready);
endinterface

// ===== hw/rtl/tcaod_cell.sv =====
// One slot of a sorted shift queue: holds a job and trades it with its neighbours.
module tcaod_cell (
   input  logic                   clock,
   input  logic                   occupied,
   input  tcaod_pkg::queue_op_type op,
   input  tcaod_pkg::entry_type   new_entry,
   input  logic                   prev_take,
   input  tcaod_pkg::entry_type   prev_entry,
   input  tcaod_pkg::entry_type   next_entry,
   output logic                   take,
   output tcaod_pkg::entry_type   entry
);

   tcaod_pkg::entry_type entry_ff;
   tcaod_pkg::entry_type entry_in;

   // New job belongs here or further ahead: slot empty, or held job arrives no earlier
   assign take  = !occupied || (entry_ff.arrival >= new_entry.arrival);
   assign entry = entry_ff;

   // Shift right on insert from the insertion point, shift left on pop
   always_comb begin
      entry_in = entry_ff;
      if (op.push) begin
         if (take) begin
            entry_in = prev_take ? prev_entry : new_entry;
         end
      end else if (op.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hw/rtl/tcaod_queue.sv =====
// Arrival-ordered job queue built as a chain of shift cells with a fill count.
module tcaod_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  tcaod_pkg::queue_op_type       op,
   input  tcaod_pkg::entry_type          new_entry,
   output tcaod_pkg::entry_type          head,
   output logic [tcaod_pkg::CNT_BITS-1:0] count
);

   localparam int DEPTH = tcaod_pkg::QUEUE_DEPTH;
   localparam int CNTW  = tcaod_pkg::CNT_BITS;

   logic [CNTW-1:0]      count_ff;
   logic [CNTW-1:0]      count_in;
   logic                 take       [DEPTH];
   tcaod_pkg::entry_type cell_entry [DEPTH];

   // Chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 prev_take;
      tcaod_pkg::entry_type prev_entry;
      tcaod_pkg::entry_type next_entry;

      if (i == 0) begin : g_first
         assign prev_take  = 1'b0;
         assign prev_entry = new_entry;
      end else begin : g_mid
         assign prev_take  = take[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_entry = cell_entry[i];
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      tcaod_cell u_cell (
         .clock      (clock),
         .occupied   (CNTW'(i) < count_ff),
         .op         (op),
         .new_entry  (new_entry),
         .prev_take  (prev_take),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .take       (take[i]),
         .entry      (cell_entry[i])
      );
   end

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (op.push) begin
         count_in = count_ff + CNTW'(1);
      end else if (op.pop) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = cell_entry[0];
   assign count = count_ff;

endmodule

// ===== hw/rtl/two_class_arrival_ordered_dispatcher_top.sv =====
// Top level of the two-class arrival-ordered dispatcher.
// Ticks and dropped inserts yield a result beat, valid in the cycle after the command beat is accepted.
// Throughput: one command per cycle; the cell chains shift as each command is accepted, and
// only a result beat held by the sink stalls the request side.
// Reset (synchronous): queues emptied, dispatch clock and id counter cleared,
// totals back to 2, no result pending; queued job contents are not cleared.
module two_class_arrival_ordered_dispatcher_top (
   input  logic                                  clock,
   input  logic                                  reset,
   tcaod_req_if.sink                             req_if,
   tcaod_rsp_if.source                           rsp_if,
   input  logic                                  csr_we,
   input  logic [tcaod_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tcaod_pkg::RES_BITS-1:0]        csr_wdata
);

   localparam int CNTW = tcaod_pkg::CNT_BITS;
   localparam int TW   = tcaod_pkg::TIME_BITS;

   logic                            accept;
   logic                            is_insert;
   logic                            is_user;
   tcaod_pkg::entry_type            new_entry;
   tcaod_pkg::queue_op_type         rt_op;
   tcaod_pkg::queue_op_type         usr_op;
   tcaod_pkg::entry_type            rt_head;
   tcaod_pkg::entry_type            usr_head;
   logic [CNTW-1:0]                 rt_count;
   logic [CNTW-1:0]                 usr_count;
   logic                            rt_full;
   logic                            usr_full;
   logic                            rt_due;
   logic                            usr_due;
   logic                            dropped;
   tcaod_pkg::entry_type            popped;
   logic                            rt_empty_next;
   logic                            usr_empty_next;

   logic [tcaod_pkg::RES_BITS-1:0]  printer_total_ff;
   logic [tcaod_pkg::RES_BITS-1:0]  cd_total_ff;
   logic [TW-1:0]                   clock_ff;
   logic [TW-1:0]                   clock_in;
   logic [tcaod_pkg::ID_BITS-1:0]   next_id_ff;
   logic [tcaod_pkg::ID_BITS-1:0]   next_id_in;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   tcaod_pkg::status_type           status_ff;
   tcaod_pkg::status_type           status_in;
   logic [tcaod_pkg::ID_BITS-1:0]   job_id_ff;
   logic [tcaod_pkg::ID_BITS-1:0]   job_id_in;
   tcaod_pkg::class_type            job_class_ff;
   tcaod_pkg::class_type            job_class_in;
   logic [tcaod_pkg::RUN_BITS-1:0]  job_run_time_ff;
   logic [tcaod_pkg::RUN_BITS-1:0]  job_run_time_in;
   logic                            both_empty_ff;
   logic                            both_empty_in;

   // Take a new beat whenever the result register is free or draining
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign is_insert    = (req_if.command == tcaod_pkg::CMD_INSERT);
   assign is_user      = (req_if.job_priority != '0);

   assign new_entry.arrival  = req_if.arrival_time;
   assign new_entry.run      = req_if.run_time;
   assign new_entry.printers = req_if.printers_wanted;
   assign new_entry.cds      = req_if.cds_wanted;
   assign new_entry.id       = next_id_ff;

   // Queue status
   assign rt_full  = (rt_count == CNTW'(tcaod_pkg::QUEUE_DEPTH));
   assign usr_full = (usr_count == CNTW'(tcaod_pkg::QUEUE_DEPTH));
   assign rt_due   = (rt_count != '0) && (rt_head.arrival <= clock_ff);
   assign usr_due  = (usr_count != '0) && (usr_head.arrival <= clock_ff);

   // Steer inserts and pops
   always_comb begin
      rt_op.push  = accept && is_insert && !is_user && !rt_full;
      usr_op.push = accept && is_insert && is_user && !usr_full;
      rt_op.pop   = accept && !is_insert && rt_due;
      usr_op.pop  = accept && !is_insert && !rt_due && usr_due;
   end

   assign dropped = is_insert && (is_user ? usr_full : rt_full);
   assign popped  = rt_due ? rt_head : usr_head;

   // Emptiness after this beat
   assign rt_empty_next  = ((rt_count == '0) && !rt_op.push)
                        || ((rt_count == CNTW'(1)) && rt_op.pop);
   assign usr_empty_next = ((usr_count == '0) && !usr_op.push)
                        || ((usr_count == CNTW'(1)) && usr_op.pop);

   tcaod_queue u_rt_queue (
      .clock     (clock),
      .reset     (reset),
      .op        (rt_op),
      .new_entry (new_entry),
      .head      (rt_head),
      .count     (rt_count)
   );

   tcaod_queue u_usr_queue (
      .clock     (clock),
      .reset     (reset),
      .op        (usr_op),
      .new_entry (new_entry),
      .head      (usr_head),
      .count     (usr_count)
   );

   // Advance id counter and dispatch clock
   always_comb begin
      next_id_in = next_id_ff;
      clock_in   = clock_ff;
      if (accept) begin
         if (is_insert) begin
            next_id_in = next_id_ff + tcaod_pkg::ID_BITS'(1);
         end else if (clock_ff != '1) begin
            clock_in = clock_ff + TW'(1);
         end
      end
   end

   // Form the result beat
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      status_in       = status_ff;
      job_id_in       = job_id_ff;
      job_class_in    = job_class_ff;
      job_run_time_in = job_run_time_ff;
      both_empty_in   = both_empty_ff;
      if (accept) begin
         rsp_valid_in    = !is_insert || dropped;
         both_empty_in   = rt_empty_next && usr_empty_next;
         job_run_time_in = '0;
         if (is_insert) begin
            status_in    = tcaod_pkg::STAT_DROPPED;
            job_id_in    = next_id_ff;
            job_class_in = is_user ? tcaod_pkg::CLASS_USER : tcaod_pkg::CLASS_REALTIME;
         end else if (rt_due || usr_due) begin
            job_id_in    = popped.id;
            job_class_in = rt_due ? tcaod_pkg::CLASS_REALTIME : tcaod_pkg::CLASS_USER;
            if ((popped.printers <= printer_total_ff) && (popped.cds <= cd_total_ff)) begin
               status_in       = tcaod_pkg::STAT_DISPATCHED;
               job_run_time_in = popped.run;
            end else begin
               status_in = tcaod_pkg::STAT_REJECTED;
            end
         end else begin
            status_in    = tcaod_pkg::STAT_IDLE;
            job_id_in    = '0;
            job_class_in = tcaod_pkg::CLASS_REALTIME;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         clock_ff         <= '0;
         next_id_ff       <= '0;
         printer_total_ff <= tcaod_pkg::PRINTER_TOTAL_RESET;
         cd_total_ff      <= tcaod_pkg::CD_TOTAL_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         clock_ff     <= clock_in;
         next_id_ff   <= next_id_in;
         if (csr_we) begin
            case (csr_index)
               tcaod_pkg::CSR_PRINTER_TOTAL: printer_total_ff <= csr_wdata;
               tcaod_pkg::CSR_CD_TOTAL:      cd_total_ff      <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      status_ff       <= status_in;
      job_id_ff       <= job_id_in;
      job_class_ff    <= job_class_in;
      job_run_time_ff <= job_run_time_in;
      both_empty_ff   <= both_empty_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.job_id       = job_id_ff;
   assign rsp_if.job_class    = job_class_ff;
   assign rsp_if.job_run_time = job_run_time_ff;
   assign rsp_if.both_empty   = both_empty_ff;

endmodule

// ===== hw/rtl/tcaod_checker.sv =====
// Port-level checks of the dispatcher, bound to the top level.
module tcaod_checker (
   input  logic                               clock,
   input  logic                               reset,
   tcaod_req_if.sink                          req_if,
   tcaod_rsp_if.source                        rsp_if
);

   // No result beat straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid after reset");

   // A stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.status)
         && $stable(rsp_if.job_id) && $stable(rsp_if.job_run_time))
      else $error("stalled result changed");

   // An insert yields nothing or a drop report
   a_insert: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && (req_if.command == tcaod_pkg::CMD_INSERT)
      |=> !rsp_if.valid || (rsp_if.status == tcaod_pkg::STAT_DROPPED))
      else $error("insert gave a non-drop result");

   // A tick always yields a result that is not a drop
   a_tick: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready && (req_if.command == tcaod_pkg::CMD_TICK)
      |=> rsp_if.valid && (rsp_if.status != tcaod_pkg::STAT_DROPPED))
      else $error("tick gave no result or a drop");

   // Only a dispatched job carries a run time
   a_run_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.status != tcaod_pkg::STAT_DISPATCHED)
      |-> (rsp_if.job_run_time == '0))
      else $error("run time on a non-dispatched result");

endmodule

bind two_class_arrival_ordered_dispatcher_top tcaod_checker u_tcaod_checker (
   .clock     (clock),
   .reset     (reset),
   .req_if    (req_if),
   .rsp_if    (rsp_if)
);
